/* hdl/positional_list_engine_assert.svh */
// Assertion macros used by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("positional list engine: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("positional list engine: assertion failed");

`endif

/* hdl/ple_pkg.sv */
// Types, codes and sizes shared by the positional list engine modules.
package ple_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int IDX_W      = $clog2(LIST_DEPTH);
	localparam int CNT_W      = 5;
	localparam int DATA_W     = 32;

	localparam logic [2:0] OP_INS_FIRST = 3'd0;
	localparam logic [2:0] OP_INS_LAST  = 3'd1;
	localparam logic [2:0] OP_INS_AT    = 3'd2;
	localparam logic [2:0] OP_DEL_FIRST = 3'd3;
	localparam logic [2:0] OP_DEL_LAST  = 3'd4;
	localparam logic [2:0] OP_DEL_AT    = 3'd5;
	localparam logic [2:0] OP_DUMP      = 3'd6;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic              re;
		logic [IDX_W-1:0]  raddr;
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [CNT_W-1:0]         count;
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} res_t;

endpackage

/* hdl/positional_list_engine.sv */
// Positional list engine top level: sequencer, element RAM and output register.
//
//  channel  handshake            payload
//  in       in_valid / in_ready  op, value, position
//  out      out_valid / out_ready status, element_count, element_value, is_last
//
// An insert that shifts nothing writes its entry and then answers, a delete just answers.
// An insert or delete that moves k trailing entries walks them one per cycle through the
// element RAM port before it writes the new entry (insert) or answers (delete).
// A dump reads one entry per cycle and emits count results, one per cycle when out_ready
// stays high; a stalled output holds the walk, and a new request is taken once the
// final result is in the output register. Reset clears the count; no RAM clearing pass.
module positional_list_engine import ple_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	input  logic [4:0]               position,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         element_count,
	output logic signed [DATA_W-1:0] element_value,
	output logic                     is_last
);

	ram_req_t            ram_req;
	logic [DATA_W-1:0]   ram_rdata;
	logic                out_free;
	logic                res_load;
	res_t                res;

	ple_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.position  (position),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	ple_ram #(
		.WIDTH (DATA_W),
		.DEPTH (LIST_DEPTH)
	) u_store (
		.clk   (clk),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata)
	);

	ple_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_load      (res_load),
		.res           (res),
		.out_free      (out_free),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.element_count (element_count),
		.element_value (element_value),
		.is_last       (is_last)
	);

endmodule

/* hdl/ple_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds its value while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/ple_seq.sv */
// Request sequencer: decodes requests and walks the element RAM to shift or dump entries.
`include "positional_list_engine_assert.svh"

module ple_seq import ple_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [2:0]               op,
	input  logic signed [DATA_W-1:0] value,
	input  logic [4:0]               position,
	output ram_req_t                 ram_req,
	input  logic [DATA_W-1:0]        ram_rdata,
	input  logic                     out_free,
	output logic                     res_load,
	output res_t                     res
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SHUP = 3'd1;
	localparam logic [2:0] S_SHDN = 3'd2;
	localparam logic [2:0] S_PUT  = 3'd3;
	localparam logic [2:0] S_DUMP = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]               state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         ptr_q;
	logic                     more_q;
	logic signed [DATA_W-1:0] value_q;
	logic [1:0]               status_q;
	logic                     rd_valid_s1;
	logic [IDX_W-1:0]         rd_addr_s1;
	logic                     last_s1;

	logic             accept;
	logic             full;
	logic             empty;
	logic             ins_pos_ok;
	logic             del_pos_ok;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] cnt_m1;
	logic [IDX_W-1:0] ins_idx;
	logic [IDX_W-1:0] del_idx;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		full       = (cnt_q == CNT_W'(LIST_DEPTH));
		empty      = (cnt_q == '0);
		ins_pos_ok = (position != '0) && ({1'b0, position} <= ({1'b0, cnt_q} + 6'd1));
		del_pos_ok = (position != '0) && (position <= cnt_q);
		pos_idx    = IDX_W'(position - 5'd1);
		cnt_m1     = IDX_W'(cnt_q - CNT_W'(1));
		unique case (op)
			OP_INS_FIRST: ins_idx = '0;
			OP_INS_LAST:  ins_idx = IDX_W'(cnt_q);
			default:      ins_idx = pos_idx;
		endcase
		unique case (op)
			OP_DEL_FIRST: del_idx = '0;
			OP_DEL_LAST:  del_idx = cnt_m1;
			default:      del_idx = pos_idx;
		endcase
	end

	always_comb begin
		ram_req  = '0;
		res_load = 1'b0;
		res      = '0;
		unique case (state_q)
			S_SHUP: begin
				ram_req.re    = more_q;
				ram_req.raddr = ptr_q;
				ram_req.we    = rd_valid_s1;
				ram_req.waddr = rd_addr_s1 + IDX_W'(1);
				ram_req.wdata = ram_rdata;
			end
			S_SHDN: begin
				ram_req.re    = more_q;
				ram_req.raddr = ptr_q;
				ram_req.we    = rd_valid_s1;
				ram_req.waddr = rd_addr_s1 - IDX_W'(1);
				ram_req.wdata = ram_rdata;
			end
			S_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_q;
				ram_req.wdata = value_q;
			end
			S_DUMP: begin
				res_load      = rd_valid_s1 && out_free;
				res.status    = ST_OK;
				res.count     = cnt_q;
				res.value     = ram_rdata;
				res.last      = last_s1;
				// The next read may only be issued once the held word has moved on.
				ram_req.re    = more_q && (!rd_valid_s1 || res_load);
				ram_req.raddr = ptr_q;
			end
			S_RESP: begin
				res_load   = out_free;
				res.status = status_q;
				res.count  = cnt_q;
				res.value  = '0;
				res.last   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			more_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (ram_req.re) begin
				rd_valid_s1 <= 1'b1;
			end else if (state_q != S_DUMP || res_load) begin
				rd_valid_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
								if (full) begin
									state_q <= S_RESP;
								end else if (op == OP_INS_AT && !ins_pos_ok) begin
									state_q <= S_RESP;
								end else if (CNT_W'(ins_idx) < cnt_q) begin
									state_q <= S_SHUP;
									more_q  <= 1'b1;
								end else begin
									state_q <= S_PUT;
								end
							end
							OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
								if (empty) begin
									state_q <= S_RESP;
								end else if (op == OP_DEL_AT && !del_pos_ok) begin
									state_q <= S_RESP;
								end else if (CNT_W'(del_idx) + CNT_W'(1) < cnt_q) begin
									state_q <= S_SHDN;
									more_q  <= 1'b1;
								end else begin
									cnt_q   <= cnt_q - CNT_W'(1);
									state_q <= S_RESP;
								end
							end
							OP_DUMP: begin
								if (empty) begin
									state_q <= S_RESP;
								end else begin
									state_q <= S_DUMP;
									more_q  <= 1'b1;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_SHUP: begin
					if (ram_req.re && ptr_q == idx_q) begin
						more_q <= 1'b0;
					end
					if (!more_q && rd_valid_s1) begin
						state_q <= S_PUT;
					end
				end
				S_SHDN: begin
					if (ram_req.re && ptr_q == cnt_m1) begin
						more_q <= 1'b0;
					end
					if (!more_q && rd_valid_s1) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_PUT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_RESP;
				end
				S_DUMP: begin
					if (ram_req.re && ptr_q == cnt_m1) begin
						more_q <= 1'b0;
					end
					if (res_load && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, walk pointer and read tags.
	always_ff @(posedge clk) begin
		if (ram_req.re) begin
			rd_addr_s1 <= ptr_q;
			last_s1    <= (ptr_q == cnt_m1);
		end
		if (accept) begin
			value_q <= value;
			unique case (op)
				OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
					idx_q <= ins_idx;
					ptr_q <= cnt_m1;
					if (full) begin
						status_q <= ST_FULL;
					end else if (op == OP_INS_AT && !ins_pos_ok) begin
						status_q <= ST_BADPOS;
					end else begin
						status_q <= ST_OK;
					end
				end
				OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
					idx_q <= del_idx;
					ptr_q <= del_idx + IDX_W'(1);
					if (empty) begin
						status_q <= ST_EMPTY;
					end else if (op == OP_DEL_AT && !del_pos_ok) begin
						status_q <= ST_BADPOS;
					end else begin
						status_q <= ST_OK;
					end
				end
				OP_DUMP: begin
					ptr_q    <= '0;
					status_q <= empty ? ST_EMPTY : ST_OK;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end else if (ram_req.re) begin
			// Inserts walk toward the front, deletes and dumps toward the back.
			if (state_q == S_SHUP) begin
				if (ptr_q != idx_q) begin
					ptr_q <= ptr_q - IDX_W'(1);
				end
			end else if (ptr_q != cnt_m1) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	`PLE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(LIST_DEPTH))
	`PLE_ASSERT_IMP(a_no_rw_clash, clk, arst_n, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr)
	`PLE_ASSERT_IMP(a_load_free, clk, arst_n, res_load, out_free)
	`PLE_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)

endmodule

/* hdl/ple_out.sv */
// Output register stage: holds one result until the consumer takes it.
module ple_out import ple_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_load,
	input  res_t                     res,
	output logic                     out_free,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         element_count,
	output logic signed [DATA_W-1:0] element_value,
	output logic                     is_last
);

	logic out_valid_q;
	res_t res_q;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign element_count = res_q.count;
	assign element_value = res_q.value;
	assign is_last       = res_q.last;

endmodule

/* test/positional_list_engine_tb.sv */
// Self-checking testbench for the positional list engine: random list traffic against a queue model.
module positional_list_engine_tb import ple_pkg::*; ();

	localparam int CLK_PERIOD     = 20;
	localparam int RANDOM_ITEMS   = 180;
	localparam int TIMEOUT_CYCLES = 200000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 2 * LIST_DEPTH + 8;

	// Code 7 has no operation behind it; the block answers it with a plain ok.
	localparam logic [2:0] OP_NONE = 3'd7;

	typedef struct packed {
		logic [2:0]               code;
		logic signed [DATA_W-1:0] val;
		logic [4:0]               pos;
		logic                     wait_drain;
	} list_req_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [2:0]               op = OP_INS_FIRST;
	logic signed [DATA_W-1:0] value = '0;
	logic [4:0]               position = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [1:0]               status;
	logic [CNT_W-1:0]         element_count;
	logic signed [DATA_W-1:0] element_value;
	logic                     is_last;

	list_req_t                pending_reqs[$];
	res_t                     results_due[$];
	logic signed [DATA_W-1:0] list_values[$];
	int                       failures = 0;
	int                       gen_count = 0;
	logic                     gate_next = 1'b0;

	positional_list_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.value         (value),
		.position      (position),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.element_count (element_count),
		.element_value (element_value),
		.is_last       (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL positional_list_engine");
		$finish;
	end

	// Applies one request to the list copy and queues the results it must produce.
	function automatic void predict_list_op(logic [2:0] code, logic signed [DATA_W-1:0] val,
			logic [4:0] pos);
		res_t r;
		int   n;
		int   p;
		logic [1:0] st;
		n = list_values.size();
		p = int'(pos);
		st = ST_OK;
		case (code)
			OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
				if (n >= LIST_DEPTH)
					st = ST_FULL;
				else if (code == OP_INS_FIRST)
					list_values.push_front(val);
				else if (code == OP_INS_LAST)
					list_values.push_back(val);
				else if (p < 1 || p > n + 1)
					st = ST_BADPOS;
				else
					list_values.insert(p - 1, val);
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
				if (n == 0)
					st = ST_EMPTY;
				else if (code == OP_DEL_FIRST)
					void'(list_values.pop_front());
				else if (code == OP_DEL_LAST)
					void'(list_values.pop_back());
				else if (p < 1 || p > n)
					st = ST_BADPOS;
				else
					list_values.delete(p - 1);
			end
			OP_DUMP: begin
				if (n == 0) begin
					st = ST_EMPTY;
				end else begin
					for (int i = 0; i < n; i++) begin
						r.status = ST_OK;
						r.count  = CNT_W'(n);
						r.value  = list_values[i];
						r.last   = (i == n - 1);
						results_due.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.status = st;
		r.count  = CNT_W'(list_values.size());
		r.value  = '0;
		r.last   = 1'b1;
		results_due.push_back(r);
	endfunction

	// Queues a request for the driver and tracks the count it will leave behind.
	function automatic void queue_req(logic [2:0] code, logic signed [DATA_W-1:0] val,
			logic [4:0] pos);
		list_req_t q;
		int p;
		q.code = code;
		q.val = val;
		q.pos = pos;
		q.wait_drain = gate_next;
		gate_next = 1'b0;
		pending_reqs.push_back(q);
		p = int'(pos);
		if (code == OP_INS_FIRST || code == OP_INS_LAST || code == OP_INS_AT) begin
			if (gen_count < LIST_DEPTH && (code != OP_INS_AT || (p >= 1 && p <= gen_count + 1)))
				gen_count++;
		end else if (code == OP_DEL_FIRST || code == OP_DEL_LAST || code == OP_DEL_AT) begin
			if (gen_count > 0 && (code != OP_DEL_AT || (p >= 1 && p <= gen_count)))
				gen_count--;
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	// Mostly a position inside 1..hi, now and then anything the field holds.
	function automatic logic [4:0] rand_pos(int hi);
		if (hi < 1 || $urandom_range(0, 7) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(1, hi));
	endfunction

	initial begin : stimulus
		int kind;
		int hits;
		int goal;
		int start;
		logic [2:0] code;

		// Directed corner cases first, starting from the empty list.
		queue_req(OP_DUMP, 32'sd0, 5'd0);
		queue_req(OP_DEL_FIRST, 32'sd0, 5'd0);
		queue_req(OP_DEL_LAST, 32'sd0, 5'd0);
		queue_req(OP_DEL_AT, 32'sd0, 5'd0);
		queue_req(OP_INS_AT, 32'sd5, 5'd0);
		queue_req(OP_INS_AT, 32'sd6, 5'd2);
		queue_req(OP_INS_AT, 32'sh8000_0000, 5'd1);
		queue_req(OP_INS_FIRST, 32'sh7fff_ffff, 5'd31);
		queue_req(OP_INS_LAST, -32'sd1, 5'd0);
		queue_req(OP_INS_AT, 32'sd0, 5'd4);
		queue_req(OP_INS_AT, 32'sh5a5a_a5a5, 5'd2);
		queue_req(OP_NONE, 32'sh1234_5678, 5'd3);
		queue_req(OP_DUMP, 32'sd0, 5'd0);
		queue_req(OP_DEL_AT, 32'sd0, 5'd0);
		queue_req(OP_DEL_AT, 32'sd0, 5'd6);
		queue_req(OP_DEL_AT, 32'sd0, 5'd31);
		queue_req(OP_DEL_AT, 32'sd0, 5'd5);
		queue_req(OP_DEL_AT, 32'sd0, 5'd2);
		queue_req(OP_DEL_FIRST, 32'sd0, 5'd0);
		queue_req(OP_DEL_LAST, 32'sd0, 5'd0);
		queue_req(OP_DUMP, 32'sd0, 5'd0);
		queue_req(OP_DEL_AT, 32'sd0, 5'd1);
		queue_req(OP_DUMP, 32'sd0, 5'd0);

		start = pending_reqs.size();
		kind = 0;
		while (pending_reqs.size() - start < RANDOM_ITEMS) begin
			gate_next = (pending_reqs.size() == start) || ($urandom_range(0, 3) == 0);
			if (kind == 0) begin
				// Fill to the top and push a few more inserts against the full list.
				goal = $urandom_range(1, 3);
				hits = 0;
				while (hits < goal) begin
					if (gen_count == LIST_DEPTH)
						hits++;
					code = 3'($urandom_range(OP_INS_FIRST, OP_INS_AT));
					queue_req(code, rand_value(), rand_pos(gen_count + 1));
				end
				queue_req(OP_DUMP, rand_value(), rand_pos(gen_count));
			end else if (kind == 1) begin
				hits = 0;
				while (hits < 1) begin
					if (gen_count == 0)
						hits++;
					code = 3'($urandom_range(OP_DEL_FIRST, OP_DEL_AT));
					queue_req(code, rand_value(), rand_pos(gen_count));
				end
				queue_req(OP_DUMP, rand_value(), rand_pos(gen_count));
			end else begin
				repeat ($urandom_range(8, 20)) begin
					code = 3'($urandom_range(OP_INS_FIRST, OP_NONE));
					if (code <= OP_INS_AT)
						queue_req(code, rand_value(), rand_pos(gen_count + 1));
					else
						queue_req(code, rand_value(), rand_pos(gen_count));
				end
			end
			kind = $urandom_range(0, 4);
		end

		@(posedge arst_n);
		while (pending_reqs.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("PASS positional_list_engine");
		else
			$display("FAIL positional_list_engine");
		$finish;
	end

	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : drive
		logic      offer;
		list_req_t nxt;
		offer = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_list_op(op, value, position);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() != 0 &&
						!(pending_reqs[0].wait_drain && results_due.size() != 0)) begin
					nxt = pending_reqs.pop_front();
					offer = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 5) == 0) begin
							burst_left = $urandom_range(30, 50);
							gap_left = 0;
						end else begin
							burst_left = $urandom_range(1, 10);
							gap_left = $urandom_range(0, 6);
						end
					end
				end
			end
			in_valid <= offer || (in_valid && !in_ready);
			if (offer) begin
				op <= nxt.code;
				value <= nxt.val;
				position <= nxt.pos;
			end
		end
	end

	int  taken = 0;
	int  hold_left = 0;
	int  run_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin : receive
		logic rdy;
		if (arst_n) begin
			if (out_valid && out_ready)
				taken++;
			// One long hold-off mid-run so the block backs up into its request side.
			if (!hold_done && taken >= 60) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (run_left > 0) begin
				run_left--;
				rdy = out_ready;
			end else begin
				case ($urandom_range(0, 9))
					6, 7, 8: begin
						rdy = 1'b0;
						run_left = $urandom_range(0, 4);
					end
					9: begin
						rdy = 1'b1;
						run_left = $urandom_range(30, 60);
					end
					default: begin
						rdy = 1'b1;
						run_left = $urandom_range(0, 15);
					end
				endcase
			end
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin : check
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result with none expected: status %0d count %0d value %0d last %0b",
					status, element_count, element_value, is_last);
				failures++;
			end else begin
				want = results_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					failures++;
				end
				if (element_count !== want.count) begin
					$error("element_count: expected %0d, got %0d", want.count, element_count);
					failures++;
				end
				if (element_value !== want.value) begin
					$error("element_value: expected %0d, got %0d", want.value, element_value);
					failures++;
				end
				if (is_last !== want.last) begin
					$error("is_last: expected %0b, got %0b", want.last, is_last);
					failures++;
				end
			end
		end
	end

endmodule
